// ===== design/fpa_pkg.sv =====
// Shared types and constants for the fixed-point ALU.
// No dependencies; imported by fpa_div_pipe and fixed_point_alu.
package fpa_pkg;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MIN = 3'd4,
		OP_MAX = 3'd5
	} op_t;

	localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	// Side data that rides along the divider stages
	typedef struct packed {
		logic [31:0] res;      // result of every path except a real divide
		logic        ovf;
		logic        dz;
		logic        gt;
		logic        lt;
		logic        eq;
		logic        use_div;  // divide with nonzero divisor
		logic        div_neg;  // quotient sign
	} tag_t;

endpackage

// ===== design/fpa_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on fpa_pkg for the side-data type carried along with each item.
module fpa_div_pipe #(
	parameter int FRACTION_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [32+FRACTION_BITS-1:0]   in_num,
	input  logic [31:0]                   in_den,
	input  fpa_pkg::tag_t                 in_tag,
	output logic                          out_valid,
	output logic [32+FRACTION_BITS-1:0]   out_q,
	output logic [31:0]                   out_rem,
	output logic [31:0]                   out_den,
	output fpa_pkg::tag_t                 out_tag
);
	import fpa_pkg::*;

	localparam int NW = 32 + FRACTION_BITS;

	logic          vld_s [0:NW];
	logic [NW-1:0] num_s [0:NW];
	logic [NW-1:0] quo_s [0:NW];
	logic [31:0]   rem_s [0:NW];
	logic [31:0]   den_s [0:NW];
	tag_t          tag_s [0:NW];

	assign vld_s[0] = in_valid;
	assign num_s[0] = in_num;
	assign quo_s[0] = '0;
	assign rem_s[0] = '0;
	assign den_s[0] = in_den;
	assign tag_s[0] = in_tag;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [32:0] r_sh;
		logic [32:0] r_diff;
		logic        ge;

		// shift in the next numerator bit, subtract when it fits
		always_comb begin
			r_sh   = {rem_s[i], num_s[i][NW-1]};
			r_diff = r_sh - {1'b0, den_s[i]};
			ge     = r_sh >= {1'b0, den_s[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			num_s[i+1] <= {num_s[i][NW-2:0], 1'b0};
			quo_s[i+1] <= {quo_s[i][NW-2:0], ge};
			rem_s[i+1] <= ge ? r_diff[31:0] : r_sh[31:0];
			den_s[i+1] <= den_s[i];
			tag_s[i+1] <= tag_s[i];
		end
	end

	assign out_valid = vld_s[NW];
	assign out_q     = quo_s[NW];
	assign out_rem   = rem_s[NW];
	assign out_den   = den_s[NW];
	assign out_tag   = tag_s[NW];

endmodule

// ===== design/fixed_point_alu.sv =====
// Fixed-point ALU: add, sub, mul, div, min, max on signed raw values.
// Order: input capture, compares, product magnitude, product rounding, then
// the divider stages (one quotient bit each), then the output registers.
// Throughput: one item per cycle; busy is always low, results cannot stall.
// Reset (arst_n low, asynchronous) clears all valid bits; payload is not reset.
// Depends on fpa_pkg and fpa_div_pipe.
module fixed_point_alu #(
	parameter int FRACTION_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic               a_greater,
	output logic               a_less,
	output logic               a_equal,
	output logic               overflow,
	output logic               divide_by_zero
);
	import fpa_pkg::*;

	localparam int NW = 32 + FRACTION_BITS;
	localparam logic [63:0] HALF = 64'd1 << (FRACTION_BITS - 1);

	assign busy = 1'b0;

	// stage 1: input capture
	logic               vld_s1;
	logic [2:0]         op_s1;
	logic signed [31:0] a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= opcode;
		a_s1  <= operand_a;
		b_s1  <= operand_b;
	end

	// stage 2: compares, add/sub, min/max, product, divider operands
	logic signed [32:0] sum_c, dif_c;
	logic [31:0]        amag_c, bmag_c;
	tag_t               tag_c;
	logic               is_mul_c;

	always_comb begin
		sum_c    = {a_s1[31], a_s1} + {b_s1[31], b_s1};
		dif_c    = {a_s1[31], a_s1} - {b_s1[31], b_s1};
		amag_c   = a_s1[31] ? 32'(-a_s1) : a_s1;
		bmag_c   = b_s1[31] ? 32'(-b_s1) : b_s1;
		tag_c    = '0;
		tag_c.gt = a_s1 > b_s1;
		tag_c.lt = a_s1 < b_s1;
		tag_c.eq = a_s1 == b_s1;
		tag_c.div_neg = a_s1[31] != b_s1[31];
		is_mul_c = 1'b0;
		case (op_s1)
			OP_ADD: begin
				tag_c.ovf = sum_c[32] != sum_c[31];
				tag_c.res = tag_c.ovf ? (sum_c[32] ? SAT_MIN : SAT_MAX) : sum_c[31:0];
			end
			OP_SUB: begin
				tag_c.ovf = dif_c[32] != dif_c[31];
				tag_c.res = tag_c.ovf ? (dif_c[32] ? SAT_MIN : SAT_MAX) : dif_c[31:0];
			end
			OP_MUL: is_mul_c = 1'b1;
			OP_DIV: begin
				if (b_s1 == 32'sd0) begin
					tag_c.dz  = 1'b1;
					tag_c.res = a_s1[31] ? SAT_MIN : ((a_s1 == 32'sd0) ? 32'd0 : SAT_MAX);
				end else begin
					tag_c.use_div = 1'b1;
				end
			end
			OP_MIN: tag_c.res = (a_s1 < b_s1) ? a_s1 : b_s1;
			OP_MAX: tag_c.res = (a_s1 > b_s1) ? a_s1 : b_s1;
			default: tag_c.res = 32'd0;
		endcase
	end

	logic               vld_s2, is_mul_s2;
	tag_t               tag_s2;
	logic signed [63:0] prod_s2;
	logic [NW-1:0]      num_s2;
	logic [31:0]        den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		is_mul_s2 <= is_mul_c;
		tag_s2    <= tag_c;
		prod_s2   <= 64'(a_s1) * 64'(b_s1);
		num_s2    <= {amag_c, FRACTION_BITS'(0)};
		den_s2    <= bmag_c;
	end

	// stage 3: product magnitude
	logic          vld_s3, is_mul_s3, mneg_s3;
	tag_t          tag_s3;
	logic [63:0]   pmag_s3;
	logic [NW-1:0] num_s3;
	logic [31:0]   den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		is_mul_s3 <= is_mul_s2;
		tag_s3    <= tag_s2;
		mneg_s3   <= prod_s2[63];
		pmag_s3   <= prod_s2[63] ? 64'(-prod_s2) : 64'(prod_s2);
		num_s3    <= num_s2;
		den_s3    <= den_s2;
	end

	// stage 4: product rounding and saturation
	logic [63:0] pq_c;
	logic        movf_c;
	tag_t        tag4_c;

	always_comb begin
		pq_c   = (pmag_s3 + HALF) >> FRACTION_BITS;
		movf_c = mneg_s3 ? (pq_c > 64'h8000_0000) : (pq_c > 64'h7fff_ffff);
		tag4_c = tag_s3;
		if (is_mul_s3) begin
			tag4_c.ovf = movf_c;
			if (movf_c) begin
				tag4_c.res = mneg_s3 ? SAT_MIN : SAT_MAX;
			end else begin
				tag4_c.res = mneg_s3 ? 32'(-pq_c[31:0]) : pq_c[31:0];
			end
		end
	end

	logic          vld_s4;
	tag_t          tag_s4;
	logic [NW-1:0] num_s4;
	logic [31:0]   den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		tag_s4 <= tag4_c;
		num_s4 <= num_s3;
		den_s4 <= den_s3;
	end

	// divider stages
	logic          dv_valid;
	logic [NW-1:0] dv_q;
	logic [31:0]   dv_rem, dv_den;
	tag_t          dv_tag;

	fpa_div_pipe #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s4),
		.in_num   (num_s4),
		.in_den   (den_s4),
		.in_tag   (tag_s4),
		.out_valid(dv_valid),
		.out_q    (dv_q),
		.out_rem  (dv_rem),
		.out_den  (dv_den),
		.out_tag  (dv_tag)
	);

	// final stage: quotient rounding, saturation, output select
	logic [NW:0]  qr_c;
	logic         dovf_c;
	logic [31:0]  res_c;
	logic         ovf_c;

	always_comb begin
		qr_c   = {1'b0, dv_q} + (NW+1)'({dv_rem, 1'b0} >= {1'b0, dv_den});
		dovf_c = dv_tag.div_neg ? (qr_c > (NW+1)'(SAT_MIN)) : (qr_c > (NW+1)'(SAT_MAX));
		res_c  = dv_tag.res;
		ovf_c  = dv_tag.ovf;
		if (dv_tag.use_div) begin
			ovf_c = dovf_c;
			if (dovf_c) begin
				res_c = dv_tag.div_neg ? SAT_MIN : SAT_MAX;
			end else begin
				res_c = dv_tag.div_neg ? 32'(-qr_c[31:0]) : qr_c[31:0];
			end
		end
	end

	logic        done_q;
	logic [31:0] res_q;
	logic        gt_q, lt_q, eq_q, ovf_q, dz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_c;
		ovf_q <= ovf_c;
		dz_q  <= dv_tag.dz;
		gt_q  <= dv_tag.gt;
		lt_q  <= dv_tag.lt;
		eq_q  <= dv_tag.eq;
	end

	assign done           = done_q;
	assign result_value   = res_q;
	assign a_greater      = gt_q;
	assign a_less         = lt_q;
	assign a_equal        = eq_q;
	assign overflow       = ovf_q;
	assign divide_by_zero = dz_q;

	// checks
	a_cmp_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot({a_greater, a_less, a_equal}))
		else $error("compare flags not one-hot");

	a_dz_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		done && divide_by_zero |-> !overflow)
		else $error("divide by zero flagged with overflow");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && overflow |-> (result_value == SAT_MAX) || (result_value == SAT_MIN))
		else $error("overflow without saturated result");

endmodule
